// ===== rtl/sbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_pkg
// Shared types and constants for the SNMP request BER parser.
// ----------------------------------------------------------------------------
package sbp_pkg;

  localparam int MAX_LENGTH_BYTES_DEF = 2;
  localparam int NUMBER_WIDTH_DEF     = 32;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] KIND_COMM  = 3'd0;
  localparam logic [2:0] KIND_REQID = 3'd1;
  localparam logic [2:0] KIND_ERR   = 3'd2;
  localparam logic [2:0] KIND_OID   = 3'd3;
  localparam logic [2:0] KIND_INT   = 3'd4;
  localparam logic [2:0] KIND_STR   = 3'd5;
  localparam logic [2:0] KIND_NULL  = 3'd6;
  localparam logic [2:0] KIND_FAULT = 3'd7;

  localparam logic [7:0] TAG_STRING = 8'h04;
  localparam logic [7:0] TAG_NULL   = 8'h05;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } req_word_t;

  typedef struct packed {
    logic [2:0]  field_kind;
    logic [31:0] field_value;
    logic        message_done;
  } res_word_t;

  typedef struct packed {
    logic [1:0] cnt;
    res_word_t  r0;
    res_word_t  r1;
  } res_pair_t;

endpackage

// ===== rtl/sbp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_parser
// Field walker: holds the parse state and turns one byte into zero, one or
// two result words.
// ----------------------------------------------------------------------------
module sbp_parser #(
  parameter int MAX_LENGTH_BYTES = sbp_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int NUMBER_WIDTH     = sbp_pkg::NUMBER_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  sbp_pkg::req_word_t word,
  output sbp_pkg::res_pair_t pair
);

  localparam int LW = $clog2(MAX_LENGTH_BYTES + 1);

  typedef enum logic [12:0] {
    PH_WAIT      = 13'b0000000000001,
    PH_SEQ       = 13'b0000000000010,
    PH_VERSION   = 13'b0000000000100,
    PH_COMMUNITY = 13'b0000000001000,
    PH_PDU       = 13'b0000000010000,
    PH_REQID     = 13'b0000000100000,
    PH_ERRSTAT   = 13'b0000001000000,
    PH_ERRIDX    = 13'b0000010000000,
    PH_VBLIST    = 13'b0000100000000,
    PH_VARBIND   = 13'b0001000000000,
    PH_OID       = 13'b0010000000000,
    PH_VALUE     = 13'b0100000000000,
    PH_END       = 13'b1000000000000
  } phase_t;

  typedef enum logic [3:0] {
    ST_TAG  = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_LENX = 4'b0100,
    ST_BODY = 4'b1000
  } stage_t;

  function automatic phase_t next_phase(input phase_t p);
    phase_t r;
    unique case (p)
      PH_SEQ:       r = PH_VERSION;
      PH_VERSION:   r = PH_COMMUNITY;
      PH_COMMUNITY: r = PH_PDU;
      PH_PDU:       r = PH_REQID;
      PH_REQID:     r = PH_ERRSTAT;
      PH_ERRSTAT:   r = PH_ERRIDX;
      PH_ERRIDX:    r = PH_VBLIST;
      PH_VBLIST:    r = PH_VARBIND;
      PH_VARBIND:   r = PH_OID;
      PH_OID:       r = PH_VALUE;
      default:      r = PH_END;
    endcase
    return r;
  endfunction

  phase_t                  parse_phase, parse_phase_next;
  stage_t                  stage, stage_next;
  logic [15:0]             bytes_left, bytes_left_next;
  logic [LW-1:0]           length_bytes_left, length_bytes_left_next;
  logic [NUMBER_WIDTH-1:0] number_accumulator, number_accumulator_next;
  logic [31:0]             oid_accumulator, oid_accumulator_next;
  logic [7:0]              value_tag, value_tag_next;
  logic                    oid_first_pending, oid_first_pending_next;

  logic [7:0]  b;
  logic [6:0]  cnt;
  logic [23:0] lv;
  logic        len_go;
  logic [15:0] len_val;
  logic        fin;
  logic [63:0] num_ext;
  logic        container;

  always_comb begin
    b       = word.data_byte;
    cnt     = b[6:0];
    lv      = '0;
    len_go  = 1'b0;
    len_val = '0;
    fin     = 1'b0;
    num_ext = '0;
    pair    = '0;

    parse_phase_next        = parse_phase;
    stage_next              = stage;
    bytes_left_next         = bytes_left;
    length_bytes_left_next  = length_bytes_left;
    number_accumulator_next = number_accumulator;
    oid_accumulator_next    = oid_accumulator;
    value_tag_next          = value_tag;
    oid_first_pending_next  = oid_first_pending;

    if (word.message_start) begin
      parse_phase_next        = PH_SEQ;
      stage_next              = ST_TAG;
      bytes_left_next         = '0;
      length_bytes_left_next  = '0;
      number_accumulator_next = '0;
      oid_accumulator_next    = '0;
      value_tag_next          = '0;
      oid_first_pending_next  = 1'b0;
    end

    if (parse_phase_next != PH_WAIT && parse_phase_next != PH_END) begin
      unique case (stage_next)
        ST_TAG: begin
          if (parse_phase_next == PH_VALUE) value_tag_next = b;
          stage_next = ST_LEN;
        end
        ST_LEN: begin
          if (parse_phase_next == PH_VALUE && value_tag_next == sbp_pkg::TAG_NULL) begin
            pair.cnt = 2'd1;
            pair.r0  = '{sbp_pkg::KIND_NULL, 32'd0, 1'b1};
            parse_phase_next = PH_END;
          end else if (!b[7]) begin
            len_go  = 1'b1;
            len_val = {8'h00, b};
          end else if (cnt == 7'd0 || cnt > 7'(MAX_LENGTH_BYTES) || cnt > 7'd3) begin
            pair.cnt = 2'd1;
            pair.r0  = '{sbp_pkg::KIND_FAULT, 32'd0, 1'b1};
            parse_phase_next = PH_END;
          end else begin
            length_bytes_left_next = cnt[LW-1:0];
            bytes_left_next        = '0;
            stage_next             = ST_LENX;
          end
        end
        ST_LENX: begin
          lv = {bytes_left_next, b};
          bytes_left_next = (lv[23:16] != 8'd0) ? 16'hFFFF : lv[15:0];
          length_bytes_left_next = length_bytes_left_next - LW'(1);
          if (length_bytes_left_next == '0) begin
            len_go  = 1'b1;
            len_val = bytes_left_next;
          end
        end
        ST_BODY: begin
          if (parse_phase_next == PH_OID) begin
            if (oid_first_pending_next) begin
              oid_first_pending_next = 1'b0;
              pair.cnt = 2'd2;
              pair.r0  = '{sbp_pkg::KIND_OID, 32'd1, 1'b0};
              pair.r1  = '{sbp_pkg::KIND_OID, 32'd3, 1'b0};
            end else begin
              oid_accumulator_next = {oid_accumulator_next[24:0], b[6:0]};
              if (!b[7]) begin
                pair.cnt = 2'd1;
                pair.r0  = '{sbp_pkg::KIND_OID, oid_accumulator_next, 1'b0};
                oid_accumulator_next = '0;
              end
            end
          end else if (parse_phase_next == PH_COMMUNITY) begin
            pair.cnt = 2'd1;
            pair.r0  = '{sbp_pkg::KIND_COMM, {24'd0, b}, 1'b0};
          end else if (parse_phase_next == PH_VALUE && value_tag_next == sbp_pkg::TAG_STRING) begin
            if (bytes_left_next > 16'd1) begin
              pair.cnt = 2'd1;
              pair.r0  = '{sbp_pkg::KIND_STR, {24'd0, b}, 1'b0};
            end else begin
              number_accumulator_next = NUMBER_WIDTH'(b);
            end
          end else begin
            number_accumulator_next = {number_accumulator_next[NUMBER_WIDTH-9:0], b};
          end
          bytes_left_next = bytes_left_next - 16'd1;
          if (bytes_left_next == 16'd0) begin
            if (parse_phase_next == PH_COMMUNITY || parse_phase_next == PH_OID) begin
              oid_accumulator_next    = '0;
              number_accumulator_next = '0;
              parse_phase_next        = next_phase(parse_phase_next);
              stage_next              = ST_TAG;
            end else begin
              fin = 1'b1;
            end
          end
        end
        default: begin
          stage_next = ST_TAG;
        end
      endcase
    end

    container = (parse_phase_next == PH_SEQ) || (parse_phase_next == PH_PDU) ||
                (parse_phase_next == PH_VBLIST) || (parse_phase_next == PH_VARBIND);

    if (len_go) begin
      bytes_left_next         = len_val;
      number_accumulator_next = '0;
      oid_accumulator_next    = '0;
      if (container) begin
        parse_phase_next = next_phase(parse_phase_next);
        stage_next       = ST_TAG;
      end else if (len_val != 16'd0) begin
        stage_next             = ST_BODY;
        oid_first_pending_next = (parse_phase_next == PH_OID);
      end else if (parse_phase_next == PH_OID) begin
        pair.cnt = 2'd2;
        pair.r0  = '{sbp_pkg::KIND_OID, 32'd1, 1'b0};
        pair.r1  = '{sbp_pkg::KIND_OID, 32'd3, 1'b0};
        parse_phase_next = PH_VALUE;
        stage_next       = ST_TAG;
      end else if (parse_phase_next == PH_VALUE) begin
        pair.cnt = 2'd1;
        pair.r0  = '{sbp_pkg::KIND_NULL, 32'd0, 1'b1};
        parse_phase_next = PH_END;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      num_ext = 64'(number_accumulator_next);
      if (parse_phase_next == PH_REQID) begin
        pair.cnt = 2'd1;
        pair.r0  = '{sbp_pkg::KIND_REQID, {16'd0, num_ext[15:0]}, 1'b0};
      end else if (parse_phase_next == PH_ERRSTAT) begin
        pair.cnt = 2'd1;
        pair.r0  = '{sbp_pkg::KIND_ERR, num_ext[31:0], 1'b0};
      end else if (parse_phase_next == PH_VALUE) begin
        pair.cnt = 2'd1;
        if (value_tag_next == sbp_pkg::TAG_STRING) begin
          pair.r0 = '{sbp_pkg::KIND_STR, {24'd0, num_ext[7:0]}, 1'b1};
        end else begin
          pair.r0 = '{sbp_pkg::KIND_INT, num_ext[31:0], 1'b1};
        end
      end
      oid_accumulator_next    = '0;
      number_accumulator_next = '0;
      parse_phase_next        = next_phase(parse_phase_next);
      stage_next              = ST_TAG;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase        <= PH_WAIT;
      stage              <= ST_TAG;
      bytes_left         <= '0;
      length_bytes_left  <= '0;
      number_accumulator <= '0;
      oid_accumulator    <= '0;
      value_tag          <= '0;
      oid_first_pending  <= 1'b0;
    end else if (take) begin
      parse_phase        <= parse_phase_next;
      stage              <= stage_next;
      bytes_left         <= bytes_left_next;
      length_bytes_left  <= length_bytes_left_next;
      number_accumulator <= number_accumulator_next;
      oid_accumulator    <= oid_accumulator_next;
      value_tag          <= value_tag_next;
      oid_first_pending  <= oid_first_pending_next;
    end
  end

endmodule

// ===== rtl/sbp_res_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbp_res_queue
// Result buffer: takes up to two words per cycle, hands out one per cycle while res_stall is low.
// ----------------------------------------------------------------------------
module sbp_res_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  sbp_pkg::res_pair_t pair,
  output logic               full,
  output logic               res_valid,
  input  logic               res_stall,
  output sbp_pkg::res_word_t res_word
);

  sbp_pkg::res_word_t q [sbp_pkg::QUEUE_DEPTH];

  logic [sbp_pkg::QUEUE_AW-1:0] wr_ptr, wr_ptr_next;
  logic [sbp_pkg::QUEUE_AW-1:0] rd_ptr, rd_ptr_next;
  logic [sbp_pkg::QUEUE_CW-1:0] count, count_next;
  logic [1:0]                   n_in;
  logic                         pop;

  assign n_in      = push ? pair.cnt : 2'd0;
  assign pop       = res_valid && !res_stall;
  assign res_valid = (count != '0);
  assign res_word  = q[rd_ptr];
  assign full      = (count > sbp_pkg::QUEUE_CW'(sbp_pkg::QUEUE_DEPTH - 2));

  always_comb begin
    wr_ptr_next = wr_ptr + sbp_pkg::QUEUE_AW'(n_in);
    rd_ptr_next = rd_ptr + sbp_pkg::QUEUE_AW'(pop);
    count_next  = count + sbp_pkg::QUEUE_CW'(n_in) - sbp_pkg::QUEUE_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (n_in != 2'd0) q[wr_ptr] <= pair.r0;
    if (n_in == 2'd2) q[wr_ptr + sbp_pkg::QUEUE_AW'(1)] <= pair.r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

endmodule

// ===== rtl/snmp_request_ber_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snmp_request_ber_parser_core
// Byte-wide SNMP request decoder: walks the BER field order and emits
// community bytes, request id, error status, OID parts and the value, or a fault word.
//
//   channel  | handshake            | word
//   ---------+----------------------+----------------------------------------
//   request  | req_valid/req_stall  | data_byte, message_start
//   result   | res_valid/res_stall  | field_kind, field_value, message_done
//
// One byte is accepted per cycle while req_stall is low; its results land in the
// result buffer on the same edge and, if it was empty, show on res_word from the next cycle.
// A byte yields zero to two results; the result port drains one per cycle while res_stall is low.
// req_stall rises while the four-entry result buffer has room for fewer
// than two words. Reset returns the parser to waiting for a message start.
// ----------------------------------------------------------------------------
module snmp_request_ber_parser_core #(
  parameter int MAX_LENGTH_BYTES = sbp_pkg::MAX_LENGTH_BYTES_DEF,
  parameter int NUMBER_WIDTH     = sbp_pkg::NUMBER_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  sbp_pkg::req_word_t req_word,
  output logic               res_valid,
  input  logic               res_stall,
  output sbp_pkg::res_word_t res_word
);

  logic               take;
  sbp_pkg::res_pair_t pair;
  logic               full;

  assign req_stall = full;
  assign take      = req_valid && !full;

  sbp_parser #(
    .MAX_LENGTH_BYTES (MAX_LENGTH_BYTES),
    .NUMBER_WIDTH     (NUMBER_WIDTH)
  ) u_parser (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .word (req_word),
    .pair (pair)
  );

  sbp_res_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .pair      (pair),
    .full      (full),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_word  (res_word)
  );

endmodule
